>>> hw/rtl/clte_pkg.sv
// Shared types, constants and helper functions of the character LCD text stream encoder.
`timescale 1ns / 1ps

package clte_pkg;

	localparam logic [1:0] KIND_CHAR   = 2'd0;
	localparam logic [1:0] KIND_CURSOR = 2'd1;
	localparam logic [1:0] KIND_NUMBER = 2'd2;

	localparam logic [7:0] CHAR_NUL = 8'd0;
	localparam logic [7:0] CHAR_TAB = 8'd9;
	localparam logic [7:0] CHAR_NL  = 8'd10;

	localparam logic [7:0] CHAR_SPACE   = 8'h20;
	localparam logic [7:0] ADDR_ODD_ROW = 8'h40;
	localparam logic [7:0] CMD_SET_ADDR = 8'h80;
	localparam logic [3:0] NIBBLE_MASK  = 4'hF;

	localparam logic RS_COMMAND = 1'b0;
	localparam logic RS_DATA    = 1'b1;

	localparam logic [16:0] RECIP_1000 = 17'd67109;
	localparam int          RECIP_SHIFT = 26;

	localparam logic [5:0] COLUMN_COUNT_RESET = 6'd16;
	localparam logic       NIBBLE_MODE_RESET  = 1'b1;
	localparam int         QUEUE_DEPTH        = 4;

	localparam logic REG_COLUMN_COUNT = 1'b0;
	localparam logic REG_NIBBLE_MODE  = 1'b1;

	typedef struct packed {
		logic            rs;
		logic [2:0]      count;
		logic [3:0][7:0] bytes;
	} entry_t;

	function automatic logic [7:0] hex_char(input logic [3:0] d);
		if (d < 4'd10) begin
			return 8'h30 + {4'b0000, d};
		end
		return 8'h37 + {4'b0000, d};
	endfunction

	function automatic logic [3:0] tens_of(input logic [6:0] r);
		logic [14:0] p;
		p = r * 8'd205;
		return p[14:11];
	endfunction

	function automatic logic [3:0] ones_of(input logic [6:0] r);
		logic [6:0] tk;
		tk = tens_of(r) * 7'd10;
		return 4'(r - tk);
	endfunction

endpackage

>>> hw/rtl/char_lcd_text_stream_encoder_core.sv
// Top level of the character LCD text stream encoder with its configuration registers.
//
// Requests arrive on the s_ stream: s_tuser carries the request kind (character, cursor
// move, decimal number) and s_tdata the character, target row, target column and number.
// Each request becomes zero to eight bus transfers on the m_ stream: m_tuser is the
// register-select flag, m_tdata the byte or nibble, and m_tlast marks the final transfer
// of the request. Requests that cause nothing (NUL, unused kind) yield no transaction.
// The APB port holds column_count at address 0 and nibble_mode at address 4.
// The first transfer of a request passes through four front pipeline stages, which carry
// the decimal conversion, then through the queue and the output register.
// Sustained throughput is one transfer per cycle while the receiver does not stall; the
// transfers of a request, from one to eight, all leave through the output register.
// A request accepted while the queue is full waits in the front stages; when the receiver
// stalls, the queue fills and s_tready falls, and nothing is lost.
// Reset clears the current row, empties the pipeline and queue, and restores
// column_count to 16 and nibble_mode to 1.
`timescale 1ns / 1ps

module char_lcd_text_stream_encoder_core #(
	parameter int QUEUE_DEPTH = clte_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // character, target_row, target_column, number
	input  logic [1:0]  s_tuser,  // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // bus_value
	output logic        m_tuser,  // register_select
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [5:0]       column_count_q;
	logic             nibble_mode_q;
	logic             push, pop, full, empty;
	clte_pkg::entry_t push_entry, head;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == clte_pkg::REG_NIBBLE_MODE) ? {31'd0, nibble_mode_q}
		: {26'd0, column_count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= clte_pkg::COLUMN_COUNT_RESET;
			nibble_mode_q  <= clte_pkg::NIBBLE_MODE_RESET;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == clte_pkg::REG_COLUMN_COUNT) begin
				column_count_q <= pwdata[5:0];
			end else begin
				nibble_mode_q <= pwdata[0];
			end
		end
	end

	clte_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.kind          (s_tuser),
		.character     (s_tdata[7:0]),
		.target_row    (s_tdata[15:8]),
		.target_column (s_tdata[23:16]),
		.number        (s_tdata[39:24]),
		.column_count  (column_count_q),
		.queue_full    (full),
		.push          (push),
		.push_entry    (push_entry)
	);

	clte_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.full       (full),
		.empty      (empty)
	);

	clte_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.nibble_mode (nibble_mode_q),
		.head        (head),
		.empty       (empty),
		.pop         (pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_rs      (m_tuser),
		.out_value   (m_tdata),
		.out_last    (m_tlast)
	);

endmodule

>>> hw/rtl/clte_front.sv
// Front part: accepts requests, tracks the row and turns each request into a byte list.
`timescale 1ns / 1ps

module clte_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          kind,
	input  logic [7:0]          character,
	input  logic [7:0]          target_row,
	input  logic [7:0]          target_column,
	input  logic [15:0]         number,
	input  logic [5:0]          column_count,
	input  logic                queue_full,
	output logic                push,
	output clte_pkg::entry_t    push_entry
);

	logic [7:0] row_q;

	logic              v_s1, v_s2, v_s3, v_s4;
	logic              num_s1, num_s2, num_s3, num_s4;
	clte_pkg::entry_t  ent_s1, ent_s2, ent_s3, ent_s4;
	logic [15:0]       val_s1;
	logic [32:0]       prod_s1;
	logic [6:0]        q_s2, q_s3, q_s4;
	logic [9:0]        rest_s2, rest_s3;
	logic [3:0]        h_s3, h_s4;
	logic [6:0]        r100_s4;

	logic              en, acc, is_nl;
	logic [7:0]        row_next, col_sel, addr;
	clte_pkg::entry_t  ent_d, num_ent;
	logic [16:0]       qk;
	logic [6:0]        q_d;
	logic [9:0]        rest_d;
	logic [15:0]       hp;
	logic [9:0]        hk;
	logic [3:0]        t_d, o_d;

	assign push     = v_s4 && (ent_s4.count != 3'd0) && !queue_full;
	assign en       = !(v_s4 && (ent_s4.count != 3'd0) && queue_full);
	assign in_ready = en;
	assign acc      = in_valid && en;

	always_comb begin
		is_nl    = (kind == clte_pkg::KIND_CHAR) && (character == clte_pkg::CHAR_NL);
		row_next = (kind == clte_pkg::KIND_CURSOR) ? target_row : row_q + 8'd1;
		col_sel  = is_nl ? 8'd0 : target_column;
		addr     = (row_next[0] ? clte_pkg::ADDR_ODD_ROW : 8'd0)
			+ ((row_next > 8'd1) ? {2'b00, column_count} : 8'd0) + col_sel;
		ent_d       = '0;
		ent_d.rs    = clte_pkg::RS_DATA;
		ent_d.bytes = {4{clte_pkg::CHAR_SPACE}};
		unique case (kind)
			clte_pkg::KIND_CHAR: begin
				if (is_nl) begin
					ent_d.rs       = clte_pkg::RS_COMMAND;
					ent_d.count    = 3'd1;
					ent_d.bytes[0] = addr | clte_pkg::CMD_SET_ADDR;
				end else if (character == clte_pkg::CHAR_TAB) begin
					ent_d.count = 3'd4;
				end else if (character != clte_pkg::CHAR_NUL) begin
					ent_d.count    = 3'd1;
					ent_d.bytes[0] = character;
				end
			end
			clte_pkg::KIND_CURSOR: begin
				ent_d.rs       = clte_pkg::RS_COMMAND;
				ent_d.count    = 3'd1;
				ent_d.bytes[0] = addr | clte_pkg::CMD_SET_ADDR;
			end
			clte_pkg::KIND_NUMBER: begin
				if (number < 16'd10) begin
					ent_d.count = 3'd1;
				end else if (number < 16'd100) begin
					ent_d.count = 3'd2;
				end else if (number < 16'd1000) begin
					ent_d.count = 3'd3;
				end else begin
					ent_d.count = 3'd4;
				end
			end
			default: begin
				ent_d.count = 3'd0;
			end
		endcase
	end

	always_comb begin
		q_d    = prod_s1[clte_pkg::RECIP_SHIFT +: 7];
		qk     = q_d * 10'd1000;
		rest_d = 10'(val_s1 - qk[15:0]);
		hp     = rest_s2 * 6'd41;
		hk     = h_s3 * 10'd100;
		t_d    = clte_pkg::tens_of(r100_s4);
		o_d    = clte_pkg::ones_of(r100_s4);
	end

	always_comb begin
		num_ent = ent_s4;
		case (ent_s4.count)
			3'd4: begin
				num_ent.bytes[0] = clte_pkg::hex_char(q_s4[3:0] & clte_pkg::NIBBLE_MASK);
				num_ent.bytes[1] = clte_pkg::hex_char(h_s4);
				num_ent.bytes[2] = clte_pkg::hex_char(t_d);
				num_ent.bytes[3] = clte_pkg::hex_char(o_d);
			end
			3'd3: begin
				num_ent.bytes[0] = clte_pkg::hex_char(h_s4);
				num_ent.bytes[1] = clte_pkg::hex_char(t_d);
				num_ent.bytes[2] = clte_pkg::hex_char(o_d);
				num_ent.bytes[3] = clte_pkg::hex_char(o_d);
			end
			3'd2: begin
				num_ent.bytes[0] = clte_pkg::hex_char(t_d);
				num_ent.bytes[1] = clte_pkg::hex_char(o_d);
				num_ent.bytes[2] = clte_pkg::hex_char(o_d);
				num_ent.bytes[3] = clte_pkg::hex_char(o_d);
			end
			default: begin
				num_ent.bytes = {4{clte_pkg::hex_char(o_d)}};
			end
		endcase
		push_entry = num_s4 ? num_ent : ent_s4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= 8'd0;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
		end else begin
			if (acc && (is_nl || (kind == clte_pkg::KIND_CURSOR))) begin
				row_q <= row_next;
			end
			if (en) begin
				v_s1 <= acc;
				v_s2 <= v_s1;
				v_s3 <= v_s2;
				v_s4 <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s1  <= (kind == clte_pkg::KIND_NUMBER);
			ent_s1  <= ent_d;
			val_s1  <= number;
			prod_s1 <= number * clte_pkg::RECIP_1000;
			num_s2  <= num_s1;
			ent_s2  <= ent_s1;
			q_s2    <= q_d;
			rest_s2 <= rest_d;
			num_s3  <= num_s2;
			ent_s3  <= ent_s2;
			q_s3    <= q_s2;
			rest_s3 <= rest_s2;
			h_s3    <= hp[15:12];
			num_s4  <= num_s3;
			ent_s4  <= ent_s3;
			q_s4    <= q_s3;
			h_s4    <= h_s3;
			r100_s4 <= 7'(rest_s3 - hk);
		end
	end

endmodule

>>> hw/rtl/clte_queue.sv
// Short queue of byte lists between the front and the back part.
`timescale 1ns / 1ps

module clte_queue #(
	parameter int DEPTH = clte_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  clte_pkg::entry_t  push_entry,
	input  logic              pop,
	output clte_pkg::entry_t  head,
	output logic              full,
	output logic              empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	clte_pkg::entry_t mem_q [DEPTH];
	logic [PW-1:0]    wr_q, rd_q;
	logic [CW-1:0]    cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

>>> hw/rtl/clte_back.sv
// Back part: walks a byte list, one bus transfer per unstalled cycle into the output register.
`timescale 1ns / 1ps

module clte_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              nibble_mode,
	input  clte_pkg::entry_t  head,
	input  logic              empty,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              out_rs,
	output logic [7:0]        out_value,
	output logic              out_last
);

	logic [1:0] idx_q;
	logic       nib_q;
	logic       adv, emit, last_byte, last;
	logic [7:0] cur;
	logic [7:0] value_d;

	assign adv       = !out_valid || out_ready;
	assign emit      = adv && !empty;
	assign cur       = head.bytes[idx_q];
	assign last_byte = ({1'b0, idx_q} == (head.count - 3'd1));
	assign last      = last_byte && (!nibble_mode || nib_q);
	assign pop       = emit && last;

	always_comb begin
		if (!nibble_mode) begin
			value_d = cur;
		end else if (nib_q) begin
			value_d = {4'b0000, cur[3:0] & clte_pkg::NIBBLE_MASK};
		end else begin
			value_d = {4'b0000, cur[7:4]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= 2'd0;
			nib_q     <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= !empty;
			if (emit) begin
				if (last) begin
					idx_q <= 2'd0;
					nib_q <= 1'b0;
				end else if (nibble_mode && !nib_q) begin
					nib_q <= 1'b1;
				end else begin
					nib_q <= 1'b0;
					idx_q <= idx_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_rs    <= head.rs;
			out_value <= value_d;
			out_last  <= last;
		end
	end

endmodule

>>> test/tb_char_lcd_text_stream_encoder_core.sv
// Self-checking testbench that compares the encoder's LCD bus transfers with predicted transfers.
`timescale 1ns / 1ps

typedef struct packed {
	logic       rs;
	logic [7:0] value;
	logic       last;
} lcd_transfer_t;

class lcd_transfer_scoreboard;
	logic [5:0]    column_count;
	logic          nibble_mode;
	logic [7:0]    current_row;
	lcd_transfer_t pending_transfers[$];
	int            failures;

	function new();
		column_count = clte_pkg::COLUMN_COUNT_RESET;
		nibble_mode = clte_pkg::NIBBLE_MODE_RESET;
		current_row = 8'd0;
		failures = 0;
	endfunction

	function void write_register(logic index, logic [31:0] value);
		if (index == clte_pkg::REG_COLUMN_COUNT) begin
			column_count = value[5:0];
		end else begin
			nibble_mode = value[0];
		end
	endfunction

	function void queue_byte(logic rs, logic [7:0] value);
		lcd_transfer_t t;
		t.rs = rs;
		t.last = 1'b0;
		if (nibble_mode) begin
			t.value = {4'h0, value[7:4]};
			pending_transfers.push_back(t);
			t.value = {4'h0, value[3:0]};
		end else begin
			t.value = value;
		end
		pending_transfers.push_back(t);
	endfunction

	function void queue_address(logic [7:0] row, logic [7:0] column);
		logic [7:0] address;
		address = row[0] ? clte_pkg::ADDR_ODD_ROW : 8'h00;
		if (row > 8'd1) begin
			address = address + {2'b00, column_count};
		end
		address = address + column;
		queue_byte(clte_pkg::RS_COMMAND, address | clte_pkg::CMD_SET_ADDR);
		current_row = row;
	endfunction

	function logic [7:0] digit_char(int unsigned d);
		string hex_digits;
		hex_digits = "0123456789ABCDEF";
		return hex_digits[d];
	endfunction

	function void note_request(logic [1:0] kind, logic [39:0] data);
		logic [7:0]    character;
		logic [7:0]    next_row;
		int unsigned   n;
		int            start_count;
		lcd_transfer_t t;
		start_count = pending_transfers.size();
		character = data[7:0];
		n = 32'(data[39:24]);
		case (kind)
			clte_pkg::KIND_CHAR: begin
				if (character == clte_pkg::CHAR_NL) begin
					next_row = current_row + 8'd1;
					queue_address(next_row, 8'd0);
				end else if (character == clte_pkg::CHAR_TAB) begin
					repeat (4) queue_byte(clte_pkg::RS_DATA, clte_pkg::CHAR_SPACE);
				end else if (character != clte_pkg::CHAR_NUL) begin
					queue_byte(clte_pkg::RS_DATA, character);
				end
			end
			clte_pkg::KIND_CURSOR: begin
				queue_address(data[15:8], data[23:16]);
			end
			clte_pkg::KIND_NUMBER: begin
				if (n >= 1000) begin
					queue_byte(clte_pkg::RS_DATA, digit_char((n / 1000) & 15));
				end
				if (n >= 100) begin
					queue_byte(clte_pkg::RS_DATA, digit_char((n % 1000) / 100));
				end
				if (n >= 10) begin
					queue_byte(clte_pkg::RS_DATA, digit_char((n % 100) / 10));
				end
				queue_byte(clte_pkg::RS_DATA, digit_char(n % 10));
			end
			default: begin
			end
		endcase
		if (pending_transfers.size() > start_count) begin
			t = pending_transfers.pop_back();
			t.last = 1'b1;
			pending_transfers.push_back(t);
		end
	endfunction

	function void note_failure(string message);
		failures++;
		if (failures <= 10) begin
			$display("%s", message);
		end
	endfunction

	function void check_transfer(logic rs, logic [7:0] value, logic last);
		lcd_transfer_t want;
		if (pending_transfers.size() == 0) begin
			note_failure($sformatf("unexpected transfer rs=%0b value=%02h last=%0b",
				rs, value, last));
			return;
		end
		want = pending_transfers.pop_front();
		if (want.rs !== rs || want.value !== value || want.last !== last) begin
			note_failure({
				$sformatf("transfer mismatch: expected rs=%0b value=%02h last=%0b",
					want.rs, want.value, want.last),
				$sformatf(", got rs=%0b value=%02h last=%0b", rs, value, last)});
		end
	endfunction

	function int pending();
		return pending_transfers.size();
	endfunction
endclass

module tb_char_lcd_text_stream_encoder_core;
	localparam logic [1:0] KIND_UNUSED   = 2'd3;
	localparam int         CYCLE_LIMIT   = 400000;
	localparam int         SETTLE_CYCLES = 16;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;  // character, target_row, target_column, number
	logic [1:0]  s_tuser;  // kind
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;  // bus_value
	logic        m_tuser;  // register_select
	logic        m_tlast;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	lcd_transfer_scoreboard bus_model;
	int sender_idle = 0;
	int receiver_idle = 0;
	int cycle_count = 0;

	char_lcd_text_stream_encoder_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("char_lcd_text_stream_encoder_core regression: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			bus_model.check_transfer(m_tuser, m_tdata, m_tlast);
		end
		m_tready <= ($urandom_range(99) >= receiver_idle);
	end

	function automatic logic [39:0] request_fields(logic [7:0] character, logic [7:0] row,
		logic [7:0] column, logic [15:0] number);
		return {number, column, row, character};
	endfunction

	task automatic send_request(logic [1:0] kind, logic [39:0] data);
		while ($urandom_range(99) < sender_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= data;
		do @(posedge clk); while (!s_tready);
		bus_model.note_request(kind, data);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (bus_model.pending() != 0);
	endtask

	task automatic write_register(logic index, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {index, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		bus_model.write_register(index, value);
		@(posedge clk);
	endtask

	task automatic random_request(output bit counted);
		logic [1:0]  kind;
		logic [39:0] data;
		int          pick;
		data = {8'($urandom), 32'($urandom)};
		counted = 1'b1;
		pick = $urandom_range(99);
		if (pick < 40) begin
			kind = clte_pkg::KIND_CHAR;
			pick = $urandom_range(19);
			if (pick < 2) begin
				data[7:0] = clte_pkg::CHAR_NL;
			end else if (pick < 4) begin
				data[7:0] = clte_pkg::CHAR_TAB;
			end else if (pick == 4) begin
				data[7:0] = clte_pkg::CHAR_NUL;
			end
			counted = (data[7:0] != clte_pkg::CHAR_NUL);
		end else if (pick < 62) begin
			kind = clte_pkg::KIND_CURSOR;
			if ($urandom_range(1)) begin
				data[15:8] = 8'($urandom_range(3));
			end
			if ($urandom_range(1)) begin
				data[23:16] = 8'($urandom_range(39));
			end
		end else if (pick < 94) begin
			kind = clte_pkg::KIND_NUMBER;
			case ($urandom_range(4))
				0: data[39:24] = 16'($urandom_range(9));
				1: data[39:24] = 16'($urandom_range(99, 10));
				2: data[39:24] = 16'($urandom_range(999, 100));
				3: data[39:24] = 16'($urandom_range(9999, 1000));
				default: begin
				end
			endcase
		end else begin
			kind = KIND_UNUSED;
			counted = 1'b0;
		end
		send_request(kind, data);
	endtask

	task automatic run_phase(int count, logic [5:0] columns, logic nibble, int s_idle,
		int r_idle, bit pause);
		int sent;
		bit counted;
		sent = 0;
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_register(clte_pkg::REG_COLUMN_COUNT, {26'($urandom), columns});
		write_register(clte_pkg::REG_NIBBLE_MODE, {31'($urandom), nibble});
		sender_idle = s_idle;
		receiver_idle = r_idle;
		while (sent < count) begin
			if (pause && sent == count / 2) begin
				drain_results();
				pause = 1'b0;
			end
			random_request(counted);
			if (counted) begin
				sent++;
			end
		end
	endtask

	initial begin
		bus_model = new();
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= clte_pkg::KIND_CHAR;
		m_tready <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		sender_idle = 8;
		receiver_idle = 88;
		send_request(clte_pkg::KIND_CHAR, request_fields(8'h41, 8'd0, 8'd0, 16'd0));
		send_request(clte_pkg::KIND_CHAR, request_fields(8'hFF, 8'd0, 8'd0, 16'd0));
		send_request(clte_pkg::KIND_CHAR,
			request_fields(clte_pkg::CHAR_NUL, 8'd0, 8'd0, 16'd0));
		send_request(clte_pkg::KIND_CHAR,
			request_fields(clte_pkg::CHAR_TAB, 8'd0, 8'd0, 16'd0));
		send_request(clte_pkg::KIND_CHAR,
			request_fields(clte_pkg::CHAR_NL, 8'd0, 8'd0, 16'd0));
		send_request(clte_pkg::KIND_CHAR,
			request_fields(clte_pkg::CHAR_NL, 8'd0, 8'd0, 16'd0));
		send_request(clte_pkg::KIND_CURSOR, request_fields(8'd0, 8'd255, 8'd255, 16'd0));
		send_request(clte_pkg::KIND_CHAR,
			request_fields(clte_pkg::CHAR_NL, 8'd0, 8'd0, 16'd0));
		send_request(clte_pkg::KIND_CURSOR, request_fields(8'd0, 8'd0, 8'd0, 16'd0));
		send_request(clte_pkg::KIND_CURSOR, request_fields(8'd0, 8'd1, 8'd0, 16'd0));
		send_request(clte_pkg::KIND_CURSOR, request_fields(8'd0, 8'd2, 8'd5, 16'd0));
		send_request(clte_pkg::KIND_CURSOR, request_fields(8'd0, 8'd3, 8'd39, 16'd0));
		send_request(KIND_UNUSED, request_fields(8'h41, 8'd3, 8'd3, 16'd1234));
		send_request(clte_pkg::KIND_NUMBER, request_fields(8'd0, 8'd0, 8'd0, 16'd0));
		send_request(clte_pkg::KIND_NUMBER, request_fields(8'd0, 8'd0, 8'd0, 16'd9));
		send_request(clte_pkg::KIND_NUMBER, request_fields(8'd0, 8'd0, 8'd0, 16'd10));
		send_request(clte_pkg::KIND_NUMBER, request_fields(8'd0, 8'd0, 8'd0, 16'd99));
		send_request(clte_pkg::KIND_NUMBER, request_fields(8'd0, 8'd0, 8'd0, 16'd100));
		send_request(clte_pkg::KIND_NUMBER, request_fields(8'd0, 8'd0, 8'd0, 16'd999));
		send_request(clte_pkg::KIND_NUMBER, request_fields(8'd0, 8'd0, 8'd0, 16'd1000));
		send_request(clte_pkg::KIND_NUMBER, request_fields(8'd0, 8'd0, 8'd0, 16'd9999));
		send_request(clte_pkg::KIND_NUMBER, request_fields(8'd0, 8'd0, 8'd0, 16'd10000));
		send_request(clte_pkg::KIND_NUMBER, request_fields(8'd0, 8'd0, 8'd0, 16'd15999));
		send_request(clte_pkg::KIND_NUMBER, request_fields(8'd0, 8'd0, 8'd0, 16'd65535));

		run_phase(60, 6'd40, 1'b1, 8, 88, 1'b0);
		run_phase(60, 6'd0, 1'b0, 88, 8, 1'b0);
		run_phase(50, 6'd63, 1'b1, 0, 0, 1'b1);
		run_phase(50, 6'd1, 1'b0, 0, 0, 1'b0);

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (bus_model.failures == 0 && bus_model.pending() == 0) begin
			$display("char_lcd_text_stream_encoder_core regression: pass");
		end else begin
			$display("char_lcd_text_stream_encoder_core regression: fail");
		end
		$finish;
	end
endmodule

>>> sim.f
hw/rtl/clte_pkg.sv
hw/rtl/clte_front.sv
hw/rtl/clte_queue.sv
hw/rtl/clte_back.sv
hw/rtl/char_lcd_text_stream_encoder_core.sv
test/tb_char_lcd_text_stream_encoder_core.sv
